[rtl/core/kinetic_scroll_controller_macros.svh]
// assertion macros for the kinetic scroll controller checker
`ifndef KINETIC_SCROLL_CONTROLLER_MACROS_SVH
`define KINETIC_SCROLL_CONTROLLER_MACROS_SVH

// same-cycle implication, disabled while rst is high
`define KSC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while rst is high
`define KSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/ksc_pkg.sv]
// shared types and constants of the kinetic scroll controller
package ksc_pkg;

   localparam int DECEL_BITS    = 8;
   localparam int LIMIT_BITS    = 12;
   localparam int CSR_DATA_BITS = 12;
   localparam int CSR_IDX_BITS  = 1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_DECEL_STEP  = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPEED_LIMIT = 1'd1;

   localparam logic [DECEL_BITS-1:0] DECEL_RESET = 8'd1;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 12'd64;

   typedef enum logic [1:0] {
      OP_PRESS   = 2'd0,
      OP_RELEASE = 2'd1,
      OP_MOVE    = 2'd2,
      OP_TICK    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      MODE_STEADY  = 3'd0,
      MODE_PRESSED = 3'd1,
      MODE_MANUAL  = 3'd2,
      MODE_AUTO    = 3'd3,
      MODE_STOP    = 3'd4
   } mode_type;

   typedef struct packed {
      logic consumed;
      logic scroll_write;
      logic replay_click;
      logic ticks_wanted;
   } rsp_flags_type;

endpackage

[rtl/core/ksc_ifs.sv]
// request and response channel interfaces of the kinetic scroll controller
interface ksc_req_if #(parameter int COORD_BITS = 16);
   logic                         valid;
   logic                         ready;
   logic [1:0]                   opcode;
   logic                         left_only;
   logic                         modifier_held;
   logic signed [COORD_BITS-1:0] pointer_x;
   logic signed [COORD_BITS-1:0] pointer_y;
   logic signed [COORD_BITS-1:0] cursor_x;
   logic signed [COORD_BITS-1:0] cursor_y;
   logic signed [COORD_BITS-1:0] scroll_now_x;
   logic signed [COORD_BITS-1:0] scroll_now_y;

   modport source (output valid, opcode, left_only, modifier_held, pointer_x, pointer_y,
                   cursor_x, cursor_y, scroll_now_x, scroll_now_y, input ready);
   modport sink (input valid, opcode, left_only, modifier_held, pointer_x, pointer_y,
                 cursor_x, cursor_y, scroll_now_x, scroll_now_y, output ready);
endinterface

interface ksc_rsp_if #(parameter int COORD_BITS = 16);
   logic                         valid;
   logic                         ready;
   logic                         consumed;
   logic                         scroll_write;
   logic signed [COORD_BITS:0]   scroll_x;
   logic signed [COORD_BITS:0]   scroll_y;
   logic                         replay_click;
   logic signed [COORD_BITS-1:0] replay_x;
   logic signed [COORD_BITS-1:0] replay_y;
   logic                         ticks_wanted;

   modport source (output valid, consumed, scroll_write, scroll_x, scroll_y, replay_click,
                   replay_x, replay_y, ticks_wanted, input ready);
   modport sink (input valid, consumed, scroll_write, scroll_x, scroll_y, replay_click,
                 replay_x, replay_y, ticks_wanted, output ready);
endinterface

[rtl/core/kinetic_scroll_controller.sv]
// kinetic scroll controller top level: request register, step logic, response register
//
//   channel | dir | handshake      | carries
//   req     | in  | valid / ready  | opcode, buttons, pointer, cursor, scroll position
//   rsp     | out | valid / ready  | consumed, scroll write, replay click, ticks wanted
//   csr     | in  | write enable   | decel_step (index 0), speed_limit (index 1)
//
// one request per cycle unless rsp stalls; rsp valid is registered from in_valid_ff.
// the step logic between the request and response registers sets the clock limit.
// synchronous active-high reset: mode steady, positions and speed zero, registers
// at their defaults; no pipeline content survives reset.
// a stalled rsp holds its payload; req keeps flowing while the request register
// can hand off to the response register.
module kinetic_scroll_controller #(
   parameter int COORD_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   ksc_req_if.sink                             req,
   ksc_rsp_if.source                           rsp,
   input  logic                                csr_write_enable,
   input  logic [ksc_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [ksc_pkg::CSR_DATA_BITS-1:0]   csr_write_data
);

   logic                                 in_valid_ff;
   logic                                 in_valid_in;
   ksc_pkg::op_type                      opcode_ff;
   logic                                 left_only_ff;
   logic                                 modifier_held_ff;
   logic signed [COORD_BITS-1:0]         pointer_x_ff;
   logic signed [COORD_BITS-1:0]         pointer_y_ff;
   logic signed [COORD_BITS-1:0]         cursor_x_ff;
   logic signed [COORD_BITS-1:0]         cursor_y_ff;
   logic signed [COORD_BITS-1:0]         scroll_now_x_ff;
   logic signed [COORD_BITS-1:0]         scroll_now_y_ff;

   logic [ksc_pkg::DECEL_BITS-1:0]       decel_step_ff;
   logic [ksc_pkg::LIMIT_BITS-1:0]       speed_limit_ff;

   ksc_pkg::mode_type                    mode_ff;
   ksc_pkg::mode_type                    mode_in;
   logic signed [COORD_BITS-1:0]         press_x_ff, press_x_in;
   logic signed [COORD_BITS-1:0]         press_y_ff, press_y_in;
   logic signed [COORD_BITS-1:0]         origin_x_ff, origin_x_in;
   logic signed [COORD_BITS-1:0]         origin_y_ff, origin_y_in;
   logic signed [COORD_BITS-1:0]         drag_x_ff, drag_x_in;
   logic signed [COORD_BITS-1:0]         drag_y_ff, drag_y_in;
   logic signed [COORD_BITS:0]           speed_x_ff, speed_x_in;
   logic signed [COORD_BITS:0]           speed_y_ff, speed_y_in;

   ksc_pkg::rsp_flags_type               flags_in;
   logic signed [COORD_BITS:0]           scroll_x_in;
   logic signed [COORD_BITS:0]           scroll_y_in;
   logic signed [COORD_BITS-1:0]         replay_x_in;
   logic signed [COORD_BITS-1:0]         replay_y_in;

   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;
   ksc_pkg::rsp_flags_type               flags_ff;
   logic signed [COORD_BITS:0]           scroll_x_ff;
   logic signed [COORD_BITS:0]           scroll_y_ff;
   logic signed [COORD_BITS-1:0]         replay_x_ff;
   logic signed [COORD_BITS-1:0]         replay_y_ff;

   logic                                 advance;
   logic                                 fire;
   logic                                 req_take;

   // response register can take a new result
   assign advance  = !rsp_valid_ff || rsp.ready;
   assign fire     = in_valid_ff && advance;
   assign req.ready = !in_valid_ff || advance;
   assign req_take = req.valid && req.ready;

   assign in_valid_in  = req_take ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         opcode_ff        <= ksc_pkg::op_type'(req.opcode);
         left_only_ff     <= req.left_only;
         modifier_held_ff <= req.modifier_held;
         pointer_x_ff     <= req.pointer_x;
         pointer_y_ff     <= req.pointer_y;
         cursor_x_ff      <= req.cursor_x;
         cursor_y_ff      <= req.cursor_y;
         scroll_now_x_ff  <= req.scroll_now_x;
         scroll_now_y_ff  <= req.scroll_now_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decel_step_ff  <= ksc_pkg::DECEL_RESET;
         speed_limit_ff <= ksc_pkg::LIMIT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            ksc_pkg::CSR_DECEL_STEP:  decel_step_ff  <= csr_write_data[ksc_pkg::DECEL_BITS-1:0];
            ksc_pkg::CSR_SPEED_LIMIT: speed_limit_ff <= csr_write_data[ksc_pkg::LIMIT_BITS-1:0];
            default: ;
         endcase
      end
   end

   ksc_step #(
      .COORD_BITS (COORD_BITS)
   ) u_step (
      .mode          (mode_ff),
      .press_x       (press_x_ff),
      .press_y       (press_y_ff),
      .origin_x      (origin_x_ff),
      .origin_y      (origin_y_ff),
      .drag_x        (drag_x_ff),
      .drag_y        (drag_y_ff),
      .speed_x       (speed_x_ff),
      .speed_y       (speed_y_ff),
      .decel_step    (decel_step_ff),
      .speed_limit   (speed_limit_ff),
      .opcode        (opcode_ff),
      .left_only     (left_only_ff),
      .modifier_held (modifier_held_ff),
      .pointer_x     (pointer_x_ff),
      .pointer_y     (pointer_y_ff),
      .cursor_x      (cursor_x_ff),
      .cursor_y      (cursor_y_ff),
      .scroll_now_x  (scroll_now_x_ff),
      .scroll_now_y  (scroll_now_y_ff),
      .mode_next     (mode_in),
      .press_x_next  (press_x_in),
      .press_y_next  (press_y_in),
      .origin_x_next (origin_x_in),
      .origin_y_next (origin_y_in),
      .drag_x_next   (drag_x_in),
      .drag_y_next   (drag_y_in),
      .speed_x_next  (speed_x_in),
      .speed_y_next  (speed_y_in),
      .flags         (flags_in),
      .scroll_x      (scroll_x_in),
      .scroll_y      (scroll_y_in),
      .replay_x      (replay_x_in),
      .replay_y      (replay_y_in)
   );

   // engine state moves only when a request leaves the request register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= ksc_pkg::MODE_STEADY;
         press_x_ff  <= '0;
         press_y_ff  <= '0;
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         drag_x_ff   <= '0;
         drag_y_ff   <= '0;
         speed_x_ff  <= '0;
         speed_y_ff  <= '0;
      end else if (fire) begin
         mode_ff     <= mode_in;
         press_x_ff  <= press_x_in;
         press_y_ff  <= press_y_in;
         origin_x_ff <= origin_x_in;
         origin_y_ff <= origin_y_in;
         drag_x_ff   <= drag_x_in;
         drag_y_ff   <= drag_y_in;
         speed_x_ff  <= speed_x_in;
         speed_y_ff  <= speed_y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         flags_ff    <= flags_in;
         scroll_x_ff <= scroll_x_in;
         scroll_y_ff <= scroll_y_in;
         replay_x_ff <= replay_x_in;
         replay_y_ff <= replay_y_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.consumed     = flags_ff.consumed;
   assign rsp.scroll_write = flags_ff.scroll_write;
   assign rsp.scroll_x     = scroll_x_ff;
   assign rsp.scroll_y     = scroll_y_ff;
   assign rsp.replay_click = flags_ff.replay_click;
   assign rsp.replay_x     = replay_x_ff;
   assign rsp.replay_y     = replay_y_ff;
   assign rsp.ticks_wanted = flags_ff.ticks_wanted;

endmodule

[rtl/core/ksc_step.sv]
// one-request update of the scroll mode, positions and speed
module ksc_step #(
   parameter int COORD_BITS = 16
) (
   input  ksc_pkg::mode_type                 mode,
   input  logic signed [COORD_BITS-1:0]      press_x,
   input  logic signed [COORD_BITS-1:0]      press_y,
   input  logic signed [COORD_BITS-1:0]      origin_x,
   input  logic signed [COORD_BITS-1:0]      origin_y,
   input  logic signed [COORD_BITS-1:0]      drag_x,
   input  logic signed [COORD_BITS-1:0]      drag_y,
   input  logic signed [COORD_BITS:0]        speed_x,
   input  logic signed [COORD_BITS:0]        speed_y,
   input  logic [ksc_pkg::DECEL_BITS-1:0]    decel_step,
   input  logic [ksc_pkg::LIMIT_BITS-1:0]    speed_limit,
   input  ksc_pkg::op_type                   opcode,
   input  logic                              left_only,
   input  logic                              modifier_held,
   input  logic signed [COORD_BITS-1:0]      pointer_x,
   input  logic signed [COORD_BITS-1:0]      pointer_y,
   input  logic signed [COORD_BITS-1:0]      cursor_x,
   input  logic signed [COORD_BITS-1:0]      cursor_y,
   input  logic signed [COORD_BITS-1:0]      scroll_now_x,
   input  logic signed [COORD_BITS-1:0]      scroll_now_y,
   output ksc_pkg::mode_type                 mode_next,
   output logic signed [COORD_BITS-1:0]      press_x_next,
   output logic signed [COORD_BITS-1:0]      press_y_next,
   output logic signed [COORD_BITS-1:0]      origin_x_next,
   output logic signed [COORD_BITS-1:0]      origin_y_next,
   output logic signed [COORD_BITS-1:0]      drag_x_next,
   output logic signed [COORD_BITS-1:0]      drag_y_next,
   output logic signed [COORD_BITS:0]        speed_x_next,
   output logic signed [COORD_BITS:0]        speed_y_next,
   output ksc_pkg::rsp_flags_type            flags,
   output logic signed [COORD_BITS:0]        scroll_x,
   output logic signed [COORD_BITS:0]        scroll_y,
   output logic signed [COORD_BITS-1:0]      replay_x,
   output logic signed [COORD_BITS-1:0]      replay_y
);

   localparam int SW = COORD_BITS + 1;
   // wide enough for the speed and the unsigned limit side by side
   localparam int CW = COORD_BITS + 14;

   // clamp to +-limit, then pull toward zero by the step
   function automatic logic signed [SW-1:0] slow_down(
      input logic signed [SW-1:0]             s,
      input logic [ksc_pkg::DECEL_BITS-1:0]   a,
      input logic [ksc_pkg::LIMIT_BITS-1:0]   lim
   );
      logic signed [CW-1:0] sw;
      logic signed [CW-1:0] lw;
      logic signed [CW-1:0] aw;
      logic signed [CW-1:0] t;
      begin
         sw = CW'(s);
         lw = $signed({{(CW-ksc_pkg::LIMIT_BITS){1'b0}}, lim});
         aw = $signed({{(CW-ksc_pkg::DECEL_BITS){1'b0}}, a});
         if (sw > lw) sw = lw;
         if (sw < -lw) sw = -lw;
         if (sw > $signed(CW'(0))) begin
            t  = sw - aw;
            sw = (t > $signed(CW'(0))) ? t : '0;
         end else if (sw < $signed(CW'(0))) begin
            t  = sw + aw;
            sw = (t < $signed(CW'(0))) ? t : '0;
         end
         return sw[SW-1:0];
      end
   endfunction

   // saturate a COORD_BITS+2 value to COORD_BITS+1
   function automatic logic signed [SW-1:0] sat_out(input logic signed [SW:0] v);
      logic signed [SW-1:0] r;
      begin
         if (v[SW] != v[SW-1]) r = v[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
         else r = v[SW-1:0];
         return r;
      end
   endfunction

   logic                 is_tick;
   logic                 mouse;
   logic                 op_press;
   logic                 op_release;
   logic                 op_move;
   logic                 auto_tick;
   logic                 manual_tick;
   logic                 manual_move;
   logic                 grab_drag;
   logic                 clear_speed;
   logic signed [SW-1:0] slow_x;
   logic signed [SW-1:0] slow_y;
   logic signed [SW-1:0] travel_x;
   logic signed [SW-1:0] travel_y;
   logic signed [SW:0]   drag_pos_x;
   logic signed [SW:0]   drag_pos_y;
   logic signed [SW:0]   coast_pos_x;
   logic signed [SW:0]   coast_pos_y;

   assign is_tick    = (opcode == ksc_pkg::OP_TICK);
   assign mouse      = !is_tick && !modifier_held;
   assign op_press   = (opcode == ksc_pkg::OP_PRESS);
   assign op_release = (opcode == ksc_pkg::OP_RELEASE);
   assign op_move    = (opcode == ksc_pkg::OP_MOVE);

   assign auto_tick   = is_tick && (mode == ksc_pkg::MODE_AUTO);
   assign manual_tick = is_tick && (mode == ksc_pkg::MODE_MANUAL);
   assign manual_move = mouse && op_move && (mode == ksc_pkg::MODE_MANUAL);
   assign grab_drag   = mouse && op_move &&
                        ((mode == ksc_pkg::MODE_PRESSED) || (mode == ksc_pkg::MODE_STOP));
   assign clear_speed = mouse && (op_press || op_release) && (mode == ksc_pkg::MODE_AUTO);

   assign slow_x = slow_down(speed_x, decel_step, speed_limit);
   assign slow_y = slow_down(speed_y, decel_step, speed_limit);

   assign travel_x    = SW'(pointer_x) - SW'(press_x);
   assign travel_y    = SW'(pointer_y) - SW'(press_y);
   assign drag_pos_x  = (SW+1)'(origin_x) - (SW+1)'(travel_x);
   assign drag_pos_y  = (SW+1)'(origin_y) - (SW+1)'(travel_y);
   assign coast_pos_x = (SW+1)'(scroll_now_x) - (SW+1)'(slow_x);
   assign coast_pos_y = (SW+1)'(scroll_now_y) - (SW+1)'(slow_y);

   // next mode
   always_comb begin
      mode_next = mode;
      if (is_tick) begin
         if (auto_tick && (slow_x == '0) && (slow_y == '0)) mode_next = ksc_pkg::MODE_STEADY;
      end else if (mouse) begin
         unique case (mode)
            ksc_pkg::MODE_STEADY: begin
               if (op_press && left_only) mode_next = ksc_pkg::MODE_PRESSED;
            end
            ksc_pkg::MODE_PRESSED: begin
               if (op_release) mode_next = ksc_pkg::MODE_STEADY;
               else if (op_move) mode_next = ksc_pkg::MODE_MANUAL;
            end
            ksc_pkg::MODE_MANUAL: begin
               if (op_release) mode_next = ksc_pkg::MODE_AUTO;
            end
            ksc_pkg::MODE_AUTO: begin
               if (op_press) mode_next = ksc_pkg::MODE_STOP;
               else if (op_release) mode_next = ksc_pkg::MODE_STEADY;
            end
            ksc_pkg::MODE_STOP: begin
               if (op_release) mode_next = ksc_pkg::MODE_STEADY;
               else if (op_move) mode_next = ksc_pkg::MODE_MANUAL;
            end
            default: mode_next = ksc_pkg::MODE_STEADY;
         endcase
      end
   end

   // consumed flag per mode
   always_comb begin
      flags.consumed = 1'b0;
      if (mouse) begin
         unique case (mode)
            ksc_pkg::MODE_STEADY:  flags.consumed = op_press && left_only;
            ksc_pkg::MODE_PRESSED: flags.consumed = op_release || op_move;
            ksc_pkg::MODE_MANUAL:  flags.consumed = op_release || op_move;
            ksc_pkg::MODE_AUTO:    flags.consumed = op_press || op_release;
            ksc_pkg::MODE_STOP:    flags.consumed = op_release || op_move;
            default:               flags.consumed = 1'b0;
         endcase
      end
   end

   // result fields and state data
   always_comb begin
      flags.scroll_write = manual_move || auto_tick;
      flags.replay_click = mouse && op_release && (mode == ksc_pkg::MODE_PRESSED);
      flags.ticks_wanted = (mode_next == ksc_pkg::MODE_MANUAL) ||
                           (mode_next == ksc_pkg::MODE_AUTO);

      scroll_x = '0;
      scroll_y = '0;
      if (manual_move) begin
         scroll_x = sat_out(drag_pos_x);
         scroll_y = sat_out(drag_pos_y);
      end else if (auto_tick) begin
         scroll_x = sat_out(coast_pos_x);
         scroll_y = sat_out(coast_pos_y);
      end

      replay_x = flags.replay_click ? press_x : '0;
      replay_y = flags.replay_click ? press_y : '0;

      press_x_next  = press_x;
      press_y_next  = press_y;
      origin_x_next = origin_x;
      origin_y_next = origin_y;
      if (mouse && op_press && left_only && (mode == ksc_pkg::MODE_STEADY)) begin
         press_x_next  = pointer_x;
         press_y_next  = pointer_y;
         origin_x_next = scroll_now_x;
         origin_y_next = scroll_now_y;
      end

      drag_x_next = drag_x;
      drag_y_next = drag_y;
      if (grab_drag || manual_tick) begin
         drag_x_next = cursor_x;
         drag_y_next = cursor_y;
      end

      speed_x_next = speed_x;
      speed_y_next = speed_y;
      if (manual_tick) begin
         speed_x_next = SW'(cursor_x) - SW'(drag_x);
         speed_y_next = SW'(cursor_y) - SW'(drag_y);
      end else if (auto_tick) begin
         speed_x_next = slow_x;
         speed_y_next = slow_y;
      end else if (clear_speed) begin
         speed_x_next = '0;
         speed_y_next = '0;
      end
   end

endmodule

[rtl/core/ksc_checker.sv]
// port-level checks of the kinetic scroll controller and their bind
`include "kinetic_scroll_controller_macros.svh"

module ksc_checker #(
   parameter int COORD_BITS = 16
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         consumed,
   input logic                         scroll_write,
   input logic signed [COORD_BITS:0]   scroll_x,
   input logic signed [COORD_BITS:0]   scroll_y,
   input logic                         replay_click,
   input logic signed [COORD_BITS-1:0] replay_x,
   input logic signed [COORD_BITS-1:0] replay_y,
   input logic                         ticks_wanted
);

   // scroll position is zero unless it is to be applied
   `KSC_ASSERT_IMPLY(a_scroll_zero, clock, reset, rsp_valid && !scroll_write, (scroll_x == '0) && (scroll_y == '0), "scroll position set without scroll_write")

   // replay position is zero unless a replay is asked for
   `KSC_ASSERT_IMPLY(a_replay_zero, clock, reset, rsp_valid && !replay_click, (replay_x == '0) && (replay_y == '0), "replay position set without replay_click")

   // a replayed click is a consumed release back to steady, never a scroll
   `KSC_ASSERT_IMPLY(a_replay_kind, clock, reset, rsp_valid && replay_click, consumed && !scroll_write && !ticks_wanted, "replay_click with inconsistent flags")

   // a stalled response stays valid and keeps consumed, scroll_write and replay_click
   `KSC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(consumed) && $stable(scroll_write) && $stable(replay_click), "stalled response changed")

endmodule

bind kinetic_scroll_controller ksc_checker #(
   .COORD_BITS (COORD_BITS)
) u_ksc_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .consumed     (rsp.consumed),
   .scroll_write (rsp.scroll_write),
   .scroll_x     (rsp.scroll_x),
   .scroll_y     (rsp.scroll_y),
   .replay_click (rsp.replay_click),
   .replay_x     (rsp.replay_x),
   .replay_y     (rsp.replay_y),
   .ticks_wanted (rsp.ticks_wanted)
);
